@@ hw/rtl/mpg_pkg.sv @@
`default_nettype none
package mpg_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int COST_BITS = 16;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int COST_W    = 16;
  localparam int TOTAL_W   = 22;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COST_W-1:0] COST_MASK = COST_W'((64'd1 << COST_BITS) - 64'd1);

  typedef logic [1:0] choice_t;
  localparam choice_t CH_LEFT     = 2'd0;
  localparam choice_t CH_STRAIGHT = 2'd1;
  localparam choice_t CH_RIGHT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(MAX_COLS);

  // Returns the clamped count minus one: zero counts as one, large values as the maximum.
  function automatic int unsigned count_m1(logic [CFG_W-1:0] v, int unsigned maxv);
    int unsigned n;
    n = 32'(v);
    if (n == 0) begin
      n = 1;
    end else if (n > maxv) begin
      n = maxv;
    end
    return n - 1;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mpg_ram.sv @@
`default_nettype none
module mpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/mpg_alu.sv @@
`default_nettype none
module mpg_alu (
  input  wire logic [mpg_pkg::TOTAL_W-1:0] add_a,
  input  wire logic [mpg_pkg::TOTAL_W-1:0] add_b,
  input  wire logic                        cmp_sum,
  input  wire logic [mpg_pkg::TOTAL_W-1:0] cmp_a,
  input  wire logic [mpg_pkg::TOTAL_W-1:0] cmp_b,
  output      logic [mpg_pkg::TOTAL_W-1:0] sum_sat,
  output      logic                        less
);

  logic [mpg_pkg::TOTAL_W:0]   sum_full;
  logic [mpg_pkg::TOTAL_W-1:0] lhs;

  always_comb begin
    sum_full = {1'b0, add_a} + {1'b0, add_b};
    sum_sat  = sum_full[mpg_pkg::TOTAL_W] ? mpg_pkg::TOTAL_MAX
                                          : sum_full[mpg_pkg::TOTAL_W-1:0];
    lhs      = cmp_sum ? sum_sat : cmp_a;
    less     = lhs < cmp_b;
  end

endmodule
`default_nettype wire

@@ hw/rtl/min_path_three_way_grid.sv @@
`default_nettype none
// A cell of row one goes from idle straight to the write state; a later cell reads and
// compares its one, two or three neighbors in the previous row in turn, since those totals
// come one at a time from one RAM read port into one shared add/compare unit.
// After the last cell, a traceback through the choice RAM fills the path buffer, then one
// result per cycle is sent, one per row.
// Reset is synchronous and active low; the result strobe cannot be stalled by the receiver.
module min_path_three_way_grid (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output      logic                                 busy,
  input  wire logic [mpg_pkg::COST_W-1:0]           in_cell_cost,
  input  wire logic                                 cfg_we,
  input  wire logic [mpg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mpg_pkg::CFG_W-1:0]            cfg_wdata,
  output      logic                                 out_strobe,
  output      logic [mpg_pkg::POS_W-1:0]            out_path_row,
  output      logic [mpg_pkg::POS_W-1:0]            out_path_col,
  output      logic [mpg_pkg::TOTAL_W-1:0]          out_least_total,
  output      logic                                 out_last_step
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_WRITE,
    S_TB_WR,
    S_TB_ADJ,
    S_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [mpg_pkg::CFG_W-1:0]     rows_in_use_r, rows_in_use_nxt;
  logic [mpg_pkg::CFG_W-1:0]     cols_in_use_r, cols_in_use_nxt;
  logic [mpg_pkg::ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [mpg_pkg::COL_W-1:0]     cur_col_r, cur_col_nxt;
  logic [mpg_pkg::TOTAL_W-1:0]   best_total_r, best_total_nxt;
  logic [mpg_pkg::COL_W-1:0]     best_col_r, best_col_nxt;
  logic [mpg_pkg::TOTAL_W-1:0]   cost_r, cost_nxt;
  logic [mpg_pkg::TOTAL_W-1:0]   least_r, least_nxt;
  mpg_pkg::choice_t              choice_r, choice_nxt;
  mpg_pkg::choice_t              cand_r, cand_nxt;
  logic                          first_r, first_nxt;
  logic [mpg_pkg::ROW_W-1:0]     tb_row_r, tb_row_nxt;
  logic [mpg_pkg::COL_W-1:0]     tb_col_r, tb_col_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  logic [mpg_pkg::POS_W-1:0]     out_row_r, out_row_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [mpg_pkg::TOTAL_W-1:0]   out_total_r, out_total_nxt;

  logic [mpg_pkg::ROW_W-1:0]     nrows_m1;
  logic [mpg_pkg::COL_W-1:0]     ncols_m1;
  logic [mpg_pkg::COL_W-1:0]     rd_col;
  logic                          accept;
  logic                          cmp_sum;
  logic [mpg_pkg::TOTAL_W-1:0]   total;
  logic                          less;

  logic [mpg_pkg::TOTAL_W-1:0]   rt_rdata;
  mpg_pkg::choice_t              cs_rdata;
  logic [mpg_pkg::COL_W-1:0]     pb_rdata;

  assign nrows_m1 = mpg_pkg::ROW_W'(mpg_pkg::count_m1(rows_in_use_r, mpg_pkg::MAX_ROWS));
  assign ncols_m1 = mpg_pkg::COL_W'(mpg_pkg::count_m1(cols_in_use_r, mpg_pkg::MAX_COLS));
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cmp_sum  = (state_r == S_WRITE);

  always_comb begin
    case (cand_r)
      mpg_pkg::CH_LEFT:  rd_col = cur_col_r - 1'b1;
      mpg_pkg::CH_RIGHT: rd_col = cur_col_r + 1'b1;
      default:           rd_col = cur_col_r;
    endcase
  end

  mpg_alu u_alu (
    .add_a   (cost_r),
    .add_b   (least_r),
    .cmp_sum (cmp_sum),
    .cmp_a   (rt_rdata),
    .cmp_b   (cmp_sum ? best_total_r : least_r),
    .sum_sat (total),
    .less    (less)
  );

  mpg_ram #(
    .WIDTH (mpg_pkg::TOTAL_W),
    .DEPTH (2 * mpg_pkg::MAX_COLS)
  ) u_row_totals (
    .clk   (clk),
    .we    (state_r == S_WRITE),
    .waddr ({cur_row_r[0], cur_col_r}),
    .wdata (total),
    .raddr ({~cur_row_r[0], rd_col}),
    .rdata (rt_rdata)
  );

  mpg_ram #(
    .WIDTH (2),
    .DEPTH (mpg_pkg::MAX_ROWS * mpg_pkg::MAX_COLS)
  ) u_choice_store (
    .clk   (clk),
    .we    (state_r == S_WRITE),
    .waddr ({cur_row_r, cur_col_r}),
    .wdata (choice_r),
    .raddr ({tb_row_r, tb_col_r}),
    .rdata (cs_rdata)
  );

  mpg_ram #(
    .WIDTH (mpg_pkg::COL_W),
    .DEPTH (mpg_pkg::MAX_ROWS)
  ) u_path_buffer (
    .clk   (clk),
    .we    (state_r == S_TB_WR),
    .waddr (tb_row_r),
    .wdata (tb_col_r),
    .raddr (tb_row_r),
    .rdata (pb_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    rows_in_use_nxt = rows_in_use_r;
    cols_in_use_nxt = cols_in_use_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    best_total_nxt  = best_total_r;
    best_col_nxt    = best_col_r;
    cost_nxt        = cost_r;
    least_nxt       = least_r;
    choice_nxt      = choice_r;
    cand_nxt        = cand_r;
    first_nxt       = first_r;
    tb_row_nxt      = tb_row_r;
    tb_col_nxt      = tb_col_r;
    out_strobe_nxt  = 1'b0;
    out_row_nxt     = out_row_r;
    out_last_nxt    = out_last_r;
    out_total_nxt   = out_total_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cost_nxt = mpg_pkg::TOTAL_W'(in_cell_cost & mpg_pkg::COST_MASK);
          if (cur_row_r == '0) begin
            least_nxt  = '0;
            choice_nxt = mpg_pkg::CH_STRAIGHT;
            state_nxt  = S_WRITE;
          end else begin
            cand_nxt  = (cur_col_r != '0) ? mpg_pkg::CH_LEFT : mpg_pkg::CH_STRAIGHT;
            first_nxt = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // Candidates come left to right, so a strict compare keeps the leftmost tie.
        if (first_r || less) begin
          least_nxt  = rt_rdata;
          choice_nxt = cand_r;
        end
        first_nxt = 1'b0;
        case (cand_r)
          mpg_pkg::CH_LEFT: begin
            cand_nxt  = mpg_pkg::CH_STRAIGHT;
            state_nxt = S_RD;
          end
          mpg_pkg::CH_STRAIGHT: begin
            if (cur_col_r != ncols_m1) begin
              cand_nxt  = mpg_pkg::CH_RIGHT;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_WRITE;
            end
          end
          default: begin
            state_nxt = S_WRITE;
          end
        endcase
      end
      S_WRITE: begin
        if (cur_row_r == nrows_m1 && (cur_col_r == '0 || less)) begin
          best_total_nxt = total;
          best_col_nxt   = cur_col_r;
        end
        if (cur_col_r != ncols_m1) begin
          cur_col_nxt = cur_col_r + 1'b1;
          state_nxt   = S_IDLE;
        end else if (cur_row_r != nrows_m1) begin
          cur_row_nxt = cur_row_r + 1'b1;
          cur_col_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          tb_row_nxt  = nrows_m1;
          tb_col_nxt  = best_col_nxt;
          state_nxt   = S_TB_WR;
        end
      end
      S_TB_WR: begin
        state_nxt = (tb_row_r == '0) ? S_EMIT : S_TB_ADJ;
      end
      S_TB_ADJ: begin
        if (cs_rdata == mpg_pkg::CH_LEFT && tb_col_r != '0) begin
          tb_col_nxt = tb_col_r - 1'b1;
        end else if (cs_rdata == mpg_pkg::CH_RIGHT && tb_col_r != ncols_m1) begin
          tb_col_nxt = tb_col_r + 1'b1;
        end
        tb_row_nxt = tb_row_r - 1'b1;
        state_nxt  = S_TB_WR;
      end
      S_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_row_nxt    = mpg_pkg::POS_W'(tb_row_r) + 1'b1;
        out_last_nxt   = (tb_row_r == nrows_m1);
        out_total_nxt  = best_total_r;
        if (tb_row_r == nrows_m1) begin
          best_total_nxt = mpg_pkg::TOTAL_MAX;
          best_col_nxt   = '0;
          state_nxt      = S_IDLE;
        end else begin
          tb_row_nxt = tb_row_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we && (cfg_index inside {mpg_pkg::REG_ROWS, mpg_pkg::REG_COLS})) begin
      if (cfg_index == mpg_pkg::REG_ROWS) begin
        rows_in_use_nxt = cfg_wdata;
      end else begin
        cols_in_use_nxt = cfg_wdata;
      end
      cur_row_nxt    = '0;
      cur_col_nxt    = '0;
      best_total_nxt = mpg_pkg::TOTAL_MAX;
      best_col_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    cost_r      <= cost_nxt;
    least_r     <= least_nxt;
    choice_r    <= choice_nxt;
    cand_r      <= cand_nxt;
    first_r     <= first_nxt;
    tb_row_r    <= tb_row_nxt;
    tb_col_r    <= tb_col_nxt;
    out_row_r   <= out_row_nxt;
    out_last_r  <= out_last_nxt;
    out_total_r <= out_total_nxt;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rows_in_use_r <= mpg_pkg::ROWS_RESET;
      cols_in_use_r <= mpg_pkg::COLS_RESET;
      cur_row_r     <= '0;
      cur_col_r     <= '0;
      best_total_r  <= mpg_pkg::TOTAL_MAX;
      best_col_r    <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rows_in_use_r <= rows_in_use_nxt;
      cols_in_use_r <= cols_in_use_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_col_r     <= cur_col_nxt;
      best_total_r  <= best_total_nxt;
      best_col_r    <= best_col_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_path_row    = out_row_r;
  assign out_path_col    = mpg_pkg::POS_W'(pb_rdata) + 1'b1;
  assign out_least_total = out_total_r;
  assign out_last_step   = out_last_r;

endmodule
`default_nettype wire

@@ hw/rtl/mpg_checker.sv @@
`default_nettype none
module mpg_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 busy,
  input wire logic                                 out_strobe,
  input wire logic [mpg_pkg::POS_W-1:0]            out_path_row,
  input wire logic [mpg_pkg::TOTAL_W-1:0]          out_least_total,
  input wire logic                                 out_last_step
);

  // A path is a run of beats with no gaps, starting at row one.
  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> out_path_row == 7'd1)
    else $error("path does not start at row one");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_step |=> out_strobe &&
      out_path_row == $past(out_path_row) + 7'd1 && $stable(out_least_total))
    else $error("path beats are not consecutive rows with one total");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_step |=> !out_strobe)
    else $error("beat follows the last step");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_step |-> busy)
    else $error("block idle while a path is still being sent");

endmodule

bind min_path_three_way_grid mpg_checker u_mpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_path_row    (out_path_row),
  .out_least_total (out_least_total),
  .out_last_step   (out_last_step)
);
`default_nettype wire
